### src/ipr_pkg.sv
// ----------------------------------------------------------------------------
// ipr_pkg
// Shared types and constants for the ICMP probe reply classifier.
// ----------------------------------------------------------------------------
package ipr_pkg;

  localparam int MAX_PACKET_BYTES = 256;
  // byte counter holds 0..MAX_PACKET_BYTES
  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  // offsets reach header + 8 + 60 + 7, one bit more than the counter covers
  localparam int CMP_W = POS_W + 1;

  localparam int HLEN_W = 6;
  localparam int WORD_W = 16;

  localparam logic [7:0] NIBBLE_MASK        = 8'h0F;
  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_UNREACHABLE   = 8'd3;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
  localparam int         ICMP_HDR_BYTES     = 8;
  localparam int         MIN_IP_HDR_BYTES   = 20;

  // register index, from paddr[2]
  localparam logic REG_IDENT    = 1'b0;
  localparam logic REG_SEQUENCE = 1'b1;
  localparam int   ADDR_W       = 3;

  typedef enum logic [1:0] {
    CLASS_ECHO          = 2'd0,
    CLASS_TIME_EXCEEDED = 2'd1,
    CLASS_UNREACHABLE   = 2'd2,
    CLASS_NOT_OURS      = 2'd3
  } reply_class_t;

  typedef struct packed {
    logic         valid;
    reply_class_t cls;
  } result_t;

endpackage

### src/ipr_apb_regs.sv
// ----------------------------------------------------------------------------
// ipr_apb_regs
// APB register file holding the expected probe identifier and sequence.
// ----------------------------------------------------------------------------
module ipr_apb_regs
  import ipr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic [WORD_W-1:0]   exp_ident,
  output logic [WORD_W-1:0]   exp_sequence
);

  logic [WORD_W-1:0] ident_r, ident_nxt;
  logic [WORD_W-1:0] seq_r, seq_nxt;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    ident_nxt = ident_r;
    seq_nxt   = seq_r;
    if (wr_en) begin
      case (paddr[2])
        REG_IDENT:    ident_nxt = pwdata[WORD_W-1:0];
        REG_SEQUENCE: seq_nxt   = pwdata[WORD_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r <= '0;
      seq_r   <= '0;
    end else begin
      ident_r <= ident_nxt;
      seq_r   <= seq_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IDENT:    prdata = {{(32-WORD_W){1'b0}}, ident_r};
      REG_SEQUENCE: prdata = {{(32-WORD_W){1'b0}}, seq_r};
      default:      prdata = '0;
    endcase
  end

  assign exp_ident    = ident_r;
  assign exp_sequence = seq_r;

endmodule

### src/ipr_parser.sv
// ----------------------------------------------------------------------------
// ipr_parser
// Input register plus the per-byte capture and the end-of-datagram decision.
// ----------------------------------------------------------------------------
module ipr_parser
  import ipr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              in_ready,
  input  logic              slot_free,
  input  logic [WORD_W-1:0] exp_ident,
  input  logic [WORD_W-1:0] exp_sequence,
  output result_t           res
);

  // input register
  logic       iv_r, iv_nxt;
  logic [7:0] ib_r;
  logic       il_r;

  // datagram state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [HLEN_W-1:0] ohl_r, ohl_nxt;
  logic [7:0]        type_r, type_nxt;
  logic [WORD_W-1:0] oid_r, oid_nxt;
  logic [WORD_W-1:0] oseq_r, oseq_nxt;
  logic [HLEN_W-1:0] ihl_r, ihl_nxt;
  logic [WORD_W-1:0] iid_r, iid_nxt;
  logic [WORD_W-1:0] iseq_r, iseq_nxt;

  logic              advance;
  logic              in_acc;
  logic              keep;
  logic [CMP_W-1:0]  posx, hx, ibx, len, avail;
  reply_class_t      cls;

  assign advance  = iv_r & (~il_r | slot_free);
  assign in_ready = ~iv_r | advance;
  assign in_acc   = in_valid & in_ready;

  always_comb begin
    iv_nxt = iv_r;
    if (in_acc)       iv_nxt = 1'b1;
    else if (advance) iv_nxt = 1'b0;
  end

  always_comb begin
    keep     = pos_r < POS_W'(MAX_PACKET_BYTES);
    posx     = CMP_W'(pos_r);
    ohl_nxt  = ohl_r;
    type_nxt = type_r;
    oid_nxt  = oid_r;
    oseq_nxt = oseq_r;
    ihl_nxt  = ihl_r;
    iid_nxt  = iid_r;
    iseq_nxt = iseq_r;
    pos_nxt  = pos_r;
    hx       = '0;
    ibx      = '0;
    if (keep) begin
      if (pos_r == '0) ohl_nxt = {ib_r[3:0] & NIBBLE_MASK[3:0], 2'b00};
      // every capture sees a header length updated by this same byte
      hx = CMP_W'(ohl_nxt);
      if (posx == hx)                         type_nxt = ib_r;
      if (posx == hx + CMP_W'(4))             oid_nxt[15:8]  = ib_r;
      if (posx == hx + CMP_W'(5))             oid_nxt[7:0]   = ib_r;
      if (posx == hx + CMP_W'(6))             oseq_nxt[15:8] = ib_r;
      if (posx == hx + CMP_W'(7))             oseq_nxt[7:0]  = ib_r;
      if (posx == hx + CMP_W'(ICMP_HDR_BYTES))
        ihl_nxt = {ib_r[3:0] & NIBBLE_MASK[3:0], 2'b00};
      ibx = hx + CMP_W'(ICMP_HDR_BYTES) + CMP_W'(ihl_nxt);
      if (posx == ibx + CMP_W'(4))            iid_nxt[15:8]  = ib_r;
      if (posx == ibx + CMP_W'(5))            iid_nxt[7:0]   = ib_r;
      if (posx == ibx + CMP_W'(6))            iseq_nxt[15:8] = ib_r;
      if (posx == ibx + CMP_W'(7))            iseq_nxt[7:0]  = ib_r;
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // decision over the state including the marked byte
  always_comb begin
    len   = CMP_W'(pos_nxt);
    avail = len - CMP_W'(ohl_nxt) - CMP_W'(ICMP_HDR_BYTES);
    cls   = CLASS_NOT_OURS;
    if (len >= CMP_W'(MIN_IP_HDR_BYTES + ICMP_HDR_BYTES) &&
        len >= CMP_W'(ohl_nxt) + CMP_W'(ICMP_HDR_BYTES)) begin
      if (type_nxt == TYPE_ECHO_REPLY) begin
        if (oid_nxt == exp_ident && oseq_nxt == exp_sequence) cls = CLASS_ECHO;
      end else if (type_nxt == TYPE_TIME_EXCEEDED || type_nxt == TYPE_UNREACHABLE) begin
        if (avail >= CMP_W'(MIN_IP_HDR_BYTES + ICMP_HDR_BYTES) &&
            avail >= CMP_W'(ihl_nxt) + CMP_W'(ICMP_HDR_BYTES) &&
            iid_nxt == exp_ident && iseq_nxt == exp_sequence) begin
          cls = (type_nxt == TYPE_TIME_EXCEEDED) ? CLASS_TIME_EXCEEDED
                                                 : CLASS_UNREACHABLE;
        end
      end
    end
  end

  assign res.valid = advance & il_r;
  assign res.cls   = cls;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ib_r <= in_byte;
      il_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r   <= 1'b0;
      pos_r  <= '0;
      ohl_r  <= '0;
      type_r <= '0;
      oid_r  <= '0;
      oseq_r <= '0;
      ihl_r  <= '0;
      iid_r  <= '0;
      iseq_r <= '0;
    end else begin
      iv_r <= iv_nxt;
      if (advance) begin
        if (il_r) begin
          // datagram done: start clean
          pos_r  <= '0;
          ohl_r  <= '0;
          type_r <= '0;
          oid_r  <= '0;
          oseq_r <= '0;
          ihl_r  <= '0;
          iid_r  <= '0;
          iseq_r <= '0;
        end else begin
          pos_r  <= pos_nxt;
          ohl_r  <= ohl_nxt;
          type_r <= type_nxt;
          oid_r  <= oid_nxt;
          oseq_r <= oseq_nxt;
          ihl_r  <= ihl_nxt;
          iid_r  <= iid_nxt;
          iseq_r <= iseq_nxt;
        end
      end
    end
  end

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_PACKET_BYTES))
    else $error("byte counter past buffer size");

  a_hlen_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    ohl_r[1:0] == 2'b00 && ihl_r[1:0] == 2'b00)
    else $error("header length not a multiple of four");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    advance && il_r |=> pos_r == '0 && ohl_r == '0)
    else $error("state not cleared after last beat");

  a_result_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> iv_r && il_r && slot_free)
    else $error("result without a last beat");

endmodule

### src/ipr_out_stage.sv
// ----------------------------------------------------------------------------
// ipr_out_stage
// Result register feeding the master-side stream.
// ----------------------------------------------------------------------------
module ipr_out_stage
  import ipr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  result_t      res,
  output logic         slot_free,
  output logic         out_valid,
  input  logic         out_ready,
  output reply_class_t out_cls
);

  logic         ov_r, ov_nxt;
  reply_class_t cls_r;

  assign slot_free = ~ov_r | out_ready;

  always_comb begin
    ov_nxt = ov_r;
    if (res.valid)      ov_nxt = 1'b1;
    else if (out_ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res.valid) cls_r <= res.cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= ov_nxt;
  end

  assign out_valid = ov_r;
  assign out_cls   = cls_r;

endmodule

### src/icmp_probe_reply_classifier.sv
// ----------------------------------------------------------------------------
// icmp_probe_reply_classifier
// Classifies a received IPv4 datagram as a reply to our ICMP probe.
// ----------------------------------------------------------------------------
// Usage:
//   The datagram enters on the in_ stream, one byte per beat, starting at the
//   IPv4 header; in_tlast marks its final byte. Only a last beat produces a
//   result beat on the out_ stream, carrying the two-bit class.
//   expected_ident (0x0) and expected_sequence (0x4) are set over APB while
//   the block is idle.
//   A last byte passes the input register, then the result register, to
//   out_tvalid. Throughput is one byte per cycle unless a last byte waits
//   for the result slot; bytes pass the input register, then capture logic.
//   Reset clears the datagram state, both registers and both valid flags.
//   When out_tready is low and a result waits, non-last bytes keep flowing;
//   a further last byte holds in the input register until the result is
//   taken, and in_tready drops behind it.
// ----------------------------------------------------------------------------
module icmp_probe_reply_classifier
  import ipr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] packet_byte
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [1:0] reply_class, rest zero
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [WORD_W-1:0] exp_ident;
  logic [WORD_W-1:0] exp_sequence;
  logic              slot_free;
  result_t           res;
  reply_class_t      out_cls;

  ipr_apb_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .exp_ident    (exp_ident),
    .exp_sequence (exp_sequence)
  );

  ipr_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_byte      (in_tdata),
    .in_last      (in_tlast),
    .in_ready     (in_tready),
    .slot_free    (slot_free),
    .exp_ident    (exp_ident),
    .exp_sequence (exp_sequence),
    .res          (res)
  );

  ipr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_cls   (out_cls)
  );

  assign out_tdata = {6'b0, out_cls};

endmodule
